// File: design/sm3_pkg.sv
`timescale 1ns / 1ps
// SM3 hash engine package: constants, round helper functions and the
// control/status types shared by the top level, the compression core and the checker.
package sm3_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned CV_WORDS    = 8;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 64;

   // Round constants; T_HIGH_ROT16 is T_HIGH already rotated for round 16
   localparam logic [31:0] T_LOW        = 32'h79cc4519;
   localparam logic [31:0] T_HIGH       = 32'h7a879d8a;
   localparam logic [31:0] T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Byte position where the length field starts, and last byte of a block
   localparam logic [5:0] LEN_POS        = 6'd56;
   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;

   localparam logic [2:0] MAX_WORD_BYTES = 3'd4;
   localparam logic [2:0] LAST_INDEX     = 3'd7;
   localparam logic [5:0] LAST_ROUND     = 6'd63;
   localparam logic [5:0] LAST_LOW_ROUND = 6'd15;

   localparam logic [31:0] SM3_IV [CV_WORDS] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   // Compression core handshake
   typedef struct packed {
      logic start;   // load block and chaining value, begin rounds
      logic clear;   // restore chaining value to the IV
   } cmp_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;    // high during the final round
   } cmp_status_type;

   // Rotate left by a constant amount (1..31)
   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl32(x, 9) ^ rotl32(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl32(x, 15) ^ rotl32(x, 23);
   endfunction

endpackage

// File: design/sm3_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for message words in and digest words out.
// Depends on nothing.
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last_word;

   modport source (output valid, data_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_last;

   modport source (output valid, digest_word, word_index, digest_last, input ready);
   modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// File: design/sm3_hash_engine.sv
`timescale 1ns / 1ps
// A word is taken while the engine is idle, then its n valid bytes are packed one per
// cycle, pausing while a full block is compressed, and the engine then returns to ready.
// The compression core loads each full 64-byte block, then does one round per cycle
// for 64 rounds. A last word then adds the padding and length bytes, a step from the
// padding to the length field, one or two compressions, then eight digest transfers,
// one per cycle while rsp ready is high. One message word at a time.
// Synchronous active-high reset: IV loaded, byte and bit counts cleared, engine ready.
module sm3_hash_engine (
   input  logic           clock,
   input  logic           reset,
   sm3_req_if.sink        req_ch,
   sm3_rsp_if.source      rsp_ch
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DATA = 6'b000010,
      ST_PAD  = 6'b000100,
      ST_LEN  = 6'b001000,
      ST_COMP = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  count_ff, count_in;
   logic        last_ff, last_in;
   logic        pad_first_ff, pad_first_in;
   logic [2:0]  len_cnt_ff, len_cnt_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bitcnt_ff, bitcnt_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        go_ff, go_in;
   logic [31:0] buf_ff [sm3_pkg::BLOCK_WORDS];
   logic [31:0] buf_in [sm3_pkg::BLOCK_WORDS];

   logic                    push;
   logic [7:0]              push_byte;
   logic [2:0]              take_bytes;
   sm3_pkg::cmp_ctrl_type   cmp_ctrl;
   sm3_pkg::cmp_status_type cmp_status;
   logic [31:0]             cv [sm3_pkg::CV_WORDS];

   // Sequencer and byte packer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      word_in      = word_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      pad_first_in = pad_first_ff;
      len_cnt_in   = len_cnt_ff;
      pos_in       = pos_ff;
      bitcnt_in    = bitcnt_ff;
      out_idx_in   = out_idx_ff;
      go_in        = 1'b0;
      buf_in       = buf_ff;
      push         = 1'b0;
      push_byte    = '0;
      cmp_ctrl.start = go_ff;
      cmp_ctrl.clear = 1'b0;
      take_bytes   = (req_ch.valid_bytes > sm3_pkg::MAX_WORD_BYTES) ? sm3_pkg::MAX_WORD_BYTES
                                                                     : req_ch.valid_bytes;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               word_in      = req_ch.data_word;
               count_in     = take_bytes;
               last_in      = req_ch.last_word;
               pad_first_in = 1'b1;
               bitcnt_in    = bitcnt_ff + {58'd0, take_bytes, 3'd0};
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (count_ff == 3'd0) begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end else begin
               push      = 1'b1;
               push_byte = word_ff[31:24];
               word_in   = {word_ff[23:0], 8'h00};
               count_in  = count_ff - 3'd1;
               ret_in    = ST_DATA;
            end
         end
         ST_PAD: begin
            // 0x80 first, then zeros up to the length field
            if (!pad_first_ff && (pos_ff == sm3_pkg::LEN_POS)) begin
               len_cnt_in = '0;
               state_in   = ST_LEN;
            end else begin
               push         = 1'b1;
               push_byte    = pad_first_ff ? sm3_pkg::PAD_BYTE : 8'h00;
               pad_first_in = 1'b0;
               ret_in       = ST_PAD;
            end
         end
         ST_LEN: begin
            // Bit count, most significant byte first
            push       = 1'b1;
            push_byte  = bitcnt_ff[63:56];
            bitcnt_in  = {bitcnt_ff[55:0], 8'h00};
            len_cnt_in = len_cnt_ff + 3'd1;
            ret_in     = (len_cnt_ff == sm3_pkg::LAST_INDEX) ? ST_OUT : ST_LEN;
         end
         ST_COMP: begin
            if (cmp_status.done) begin
               state_in = ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == sm3_pkg::LAST_INDEX) begin
                  pos_in         = '0;
                  bitcnt_in      = '0;
                  cmp_ctrl.clear = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Byte write into the block buffer; a full block starts compression
      if (push) begin
         case (pos_ff[1:0])
            2'd0:    buf_in[pos_ff[5:2]]        = {push_byte, 24'h000000};
            2'd1:    buf_in[pos_ff[5:2]][23:16] = push_byte;
            2'd2:    buf_in[pos_ff[5:2]][15:8]  = push_byte;
            default: buf_in[pos_ff[5:2]][7:0]   = push_byte;
         endcase
         pos_in = pos_ff + 6'd1;
         if (pos_ff == sm3_pkg::BLOCK_LAST_POS) begin
            go_in    = 1'b1;
            state_in = ST_COMP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         bitcnt_ff  <= '0;
         out_idx_ff <= '0;
         go_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         bitcnt_ff  <= bitcnt_in;
         out_idx_ff <= out_idx_in;
         go_ff      <= go_in;
      end
      ret_ff       <= ret_in;
      word_ff      <= word_in;
      count_ff     <= count_in;
      last_ff      <= last_in;
      pad_first_ff <= pad_first_in;
      len_cnt_ff   <= len_cnt_in;
      buf_ff       <= buf_in;
   end

   sm3_compress u_compress (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (cmp_ctrl),
      .block  (buf_ff),
      .status (cmp_status),
      .cv     (cv)
   );

   // Channel outputs
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = (state_ff == ST_OUT);
   assign rsp_ch.digest_word = cv[out_idx_ff];
   assign rsp_ch.word_index  = out_idx_ff;
   assign rsp_ch.digest_last = (out_idx_ff == sm3_pkg::LAST_INDEX);

endmodule

// File: design/sm3_compress.sv
`timescale 1ns / 1ps
// SM3 compression core: one round per cycle on a shared round datapath,
// 16-word expansion shift line and the chaining value. Depends on sm3_pkg.
module sm3_compress (
   input  logic                   clock,
   input  logic                   reset,
   input  sm3_pkg::cmp_ctrl_type  ctrl,
   input  logic [31:0]            block [sm3_pkg::BLOCK_WORDS],
   output sm3_pkg::cmp_status_type status,
   output logic [31:0]            cv    [sm3_pkg::CV_WORDS]
);

   logic        busy_ff, busy_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] t_ff, t_in;
   logic [31:0] w_ff  [sm3_pkg::BLOCK_WORDS];
   logic [31:0] w_in  [sm3_pkg::BLOCK_WORDS];
   logic [31:0] r_ff  [sm3_pkg::CV_WORDS];
   logic [31:0] r_in  [sm3_pkg::CV_WORDS];
   logic [31:0] cv_ff [sm3_pkg::CV_WORDS];
   logic [31:0] cv_in [sm3_pkg::CV_WORDS];

   logic [31:0] a12, ss1, ss2, fcomb, gcomb, tt1, tt2, w_new;
   logic        low_rounds;
   logic        last_round;

   // Round datapath, registers A..H are r_ff[0..7], window holds W[j..j+15]
   always_comb begin
      low_rounds = (rnd_ff <= sm3_pkg::LAST_LOW_ROUND);
      last_round = busy_ff && (rnd_ff == sm3_pkg::LAST_ROUND);
      a12 = sm3_pkg::rotl32(r_ff[0], 12);
      ss1 = sm3_pkg::rotl32(a12 + r_ff[4] + t_ff, 7);
      ss2 = ss1 ^ a12;
      if (low_rounds) begin
         fcomb = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gcomb = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         fcomb = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gcomb = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = fcomb + r_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gcomb + r_ff[7] + ss1 + w_ff[0];
      // W[j+16] from taps of the window
      w_new = sm3_pkg::perm1(w_ff[0] ^ w_ff[7] ^ sm3_pkg::rotl32(w_ff[13], 15))
              ^ sm3_pkg::rotl32(w_ff[3], 7) ^ w_ff[10];
   end

   // Next-state logic
   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      t_in    = t_ff;
      w_in    = w_ff;
      r_in    = r_ff;
      cv_in   = cv_ff;
      if (ctrl.clear) begin
         cv_in = sm3_pkg::SM3_IV;
      end
      if (ctrl.start) begin
         busy_in = 1'b1;
         rnd_in  = '0;
         t_in    = sm3_pkg::T_LOW;
         w_in    = block;
         r_in    = cv_ff;
      end else if (busy_ff) begin
         rnd_in = rnd_ff + 6'd1;
         t_in   = (rnd_ff == sm3_pkg::LAST_LOW_ROUND) ? sm3_pkg::T_HIGH_ROT16
                                                     : sm3_pkg::rotl32(t_ff, 1);
         for (int i = 0; i < sm3_pkg::BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[sm3_pkg::BLOCK_WORDS - 1] = w_new;
         r_in[0] = tt1;
         r_in[1] = r_ff[0];
         r_in[2] = sm3_pkg::rotl32(r_ff[1], 9);
         r_in[3] = r_ff[2];
         r_in[4] = sm3_pkg::perm0(tt2);
         r_in[5] = r_ff[4];
         r_in[6] = sm3_pkg::rotl32(r_ff[5], 19);
         r_in[7] = r_ff[6];
         // Feed-forward into the chaining value after the last round
         if (last_round) begin
            busy_in = 1'b0;
            for (int i = 0; i < sm3_pkg::CV_WORDS; i++) begin
               cv_in[i] = cv_ff[i] ^ r_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cv_ff   <= sm3_pkg::SM3_IV;
      end else begin
         busy_ff <= busy_in;
         cv_ff   <= cv_in;
      end
      rnd_ff <= rnd_in;
      t_ff   <= t_in;
      w_ff   <= w_in;
      r_ff   <= r_in;
   end

   assign status.busy = busy_ff;
   assign status.done = last_round;
   assign cv          = cv_ff;

endmodule

// File: design/sm3_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the SM3 hash engine, bound to the top level.
// Depends on sm3_pkg.
module sm3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_digest_last
);

   // No new message word is taken while a digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while digest output active");

   // A stalled digest word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index)
                                 && $stable(rsp_digest_word))
      else $error("stalled digest word changed");

   // Digest words go out in order, back to back
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_digest_last
      |=> rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index out of sequence");

   // Last flag marks exactly the final index
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_last == (rsp_word_index == sm3_pkg::LAST_INDEX)))
      else $error("digest_last does not match word index");

   // After the last digest transfer the engine is ready for a new message
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_digest_last |=> !rsp_valid && req_ready)
      else $error("engine not ready after digest");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_digest_word (rsp_ch.digest_word),
   .rsp_word_index  (rsp_ch.word_index),
   .rsp_digest_last (rsp_ch.digest_last)
);

// File: verif/sm3_hash_checker.sv
`timescale 1ns / 1ps
// Digest checker for the SM3 hash engine: watches both stream channels, predicts the digest
// of each message from the words it sees accepted and compares every digest word.
// Depends on sm3_pkg (constants) and the sm3_req_if / sm3_rsp_if interfaces.
module sm3_hash_checker (
   input  logic clock,
   input  logic reset,
   sm3_req_if   req_mon,
   sm3_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_words,
   output int   compared_words
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  word_pos;
      logic        last;
   } digest_item_type;

   // Expected digest words, oldest first
   digest_item_type digest_q[$];

   // Predictor state: chaining value, partial block, fill level, message length in bits
   logic [31:0] chain_v [sm3_pkg::CV_WORDS];
   logic [31:0] block_w [sm3_pkg::BLOCK_WORDS];
   int unsigned fill_bytes;
   logic [63:0] bit_total;

   int errs     = 0;
   int compared = 0;
   digest_item_type want;

   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
      logic [63:0] twice;
      twice = {x, x};
      return twice[(63 - n) -: 32];
   endfunction

   function automatic logic [31:0] p0_mix(input logic [31:0] x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic logic [31:0] p1_mix(input logic [31:0] x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   task automatic clear_state();
      for (int i = 0; i < sm3_pkg::CV_WORDS; i++)
         chain_v[i] = sm3_pkg::SM3_IV[i];
      fill_bytes = 0;
      bit_total  = '0;
   endtask

   // Full expansion to 68 words, then 64 rounds, folded into the chaining value
   task automatic compress_block();
      logic [31:0] w [68];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] ss1, ss2, tt1, tt2, ff, gg, tj;
      for (int j = 0; j < sm3_pkg::BLOCK_WORDS; j++)
         w[j] = block_w[j];
      for (int j = 16; j < 68; j++)
         w[j] = p1_mix(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
      {a, b, c, d} = {chain_v[0], chain_v[1], chain_v[2], chain_v[3]};
      {e, f, g, h} = {chain_v[4], chain_v[5], chain_v[6], chain_v[7]};
      for (int j = 0; j < sm3_pkg::ROUNDS; j++) begin
         tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
         ss1 = rol(rol(a, 12) + e + rol(tj, j % 32), 7);
         ss2 = ss1 ^ rol(a, 12);
         if (j < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
         tt2 = gg + h + ss1 + w[j];
         d = c;
         c = rol(b, 9);
         b = a;
         a = tt1;
         h = g;
         g = rol(f, 19);
         f = e;
         e = p0_mix(tt2);
      end
      chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
      chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
   endtask

   task automatic push_byte(input logic [7:0] value);
      block_w[fill_bytes / 4][31 - 8 * (fill_bytes % 4) -: 8] = value;
      fill_bytes++;
      if (fill_bytes == 64) begin
         compress_block();
         fill_bytes = 0;
      end
   endtask

   // Take one message word; on the last word pad, finish and queue the digest
   task automatic absorb_word(input logic [31:0] data, input logic [2:0] count,
                              input logic last);
      int unsigned n;
      logic [63:0] len_bits;
      // byte counts above four are clipped
      n = (count > sm3_pkg::MAX_WORD_BYTES) ? sm3_pkg::MAX_WORD_BYTES : count;
      for (int i = 0; i < n; i++)
         push_byte(data[31 - 8 * i -: 8]);
      bit_total = bit_total + 64'(n * 8);
      if (last) begin
         len_bits = bit_total;
         push_byte(sm3_pkg::PAD_BYTE);
         while (fill_bytes != sm3_pkg::LEN_POS)
            push_byte(8'h00);
         for (int i = 0; i < 8; i++)
            push_byte(len_bits[63 - 8 * i -: 8]);
         for (int i = 0; i < sm3_pkg::CV_WORDS; i++)
            digest_q.push_back('{word: chain_v[i], word_pos: 3'(i),
                                 last: (i == sm3_pkg::LAST_INDEX)});
         clear_state();
      end
   endtask

   // Compare digest transfers, then fold in accepted message words
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         digest_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            compared++;
            if (digest_q.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                           rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.digest_last);
            end else begin
               want = digest_q.pop_front();
               if (rsp_mon.digest_word !== want.word || rsp_mon.word_index !== want.word_pos ||
                   rsp_mon.digest_last !== want.last) begin
                  errs++;
                  if (errs <= 10)
                     $display("%0t: digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                              $time, want.word, want.word_pos, want.last,
                              rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.digest_last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_word(req_mon.data_word, req_mon.valid_bytes, req_mon.last_word);
      end
      mismatch_count <= errs;
      pending_words  <= digest_q.size();
      compared_words <= compared;
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Top of the SM3 hash engine testbench: clock, reset, message stimulus with bursts and
// gaps, a stalling digest receiver, a watchdog and the verdict. Needs the RTL and checker.
module testbench;

   localparam int IDLE_LIMIT   = 6000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int RANDOM_ITEMS = 200;
   localparam int TAIL_CYCLES  = 200;

   typedef enum int {STALL_NONE, STALL_PATTERN, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm3_req_if req ();
   sm3_rsp_if rsp ();

   int mismatch_count;
   int pending_words;
   int compared_words;

   int burst_left     = 0;
   int words_sent     = 0;
   int messages_sent  = 0;
   int idle_cycles    = 0;
   logic random_phase = 1'b0;

   always #1 clock = ~clock;

   sm3_hash_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   sm3_hash_checker digest_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req),
      .rsp_mon        (rsp),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words),
      .compared_words (compared_words)
   );

   // Mostly random words, with all-zero and all-one words mixed in
   function automatic logic [31:0] pick_data();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return 32'h0000_0000;
      if (roll == 1)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // One word transfer; the sender may idle between bursts of random length
   task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req.valid       <= 1'b1;
      req.data_word   <= data;
      req.valid_bytes <= count;
      req.last_word   <= last;
      do @(posedge clock); while (!req.ready);
      burst_left--;
      words_sent++;
      if (last)
         messages_sent++;
   endtask

   // Random message: short ones, ones ending near the block boundary, multi-block ones
   // and noisy ones with arbitrary byte counts
   task automatic send_random_message();
      int kind;
      int nwords;
      logic [2:0] count;
      kind = $urandom_range(0, 9);
      if (kind <= 5)
         nwords = $urandom_range(0, 8);
      else if (kind <= 7)
         nwords = $urandom_range(13, 16);
      else if (kind == 8)
         nwords = $urandom_range(17, 34);
      else
         nwords = $urandom_range(1, 10);
      for (int i = 0; i < nwords; i++) begin
         if (kind == 9)
            count = 3'($urandom_range(0, 7));
         else if ($urandom_range(0, 7) == 0)
            count = 3'($urandom_range(0, 3));
         else
            count = sm3_pkg::MAX_WORD_BYTES;
         send_word(pick_data(), count, 1'b0);
      end
      send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1);
   endtask

   // Stimulus and verdict
   initial begin
      int stop_at;
      req.valid       <= 1'b0;
      req.data_word   <= '0;
      req.valid_bytes <= '0;
      req.last_word   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty message, data bits ignored
      send_word($urandom, 3'd0, 1'b1);
      // "abc" with a junk trailing byte
      send_word(32'h616263FF, 3'd3, 1'b1);
      // full word of ones, then an oversized count on the last word
      send_word(32'hFFFF_FFFF, sm3_pkg::MAX_WORD_BYTES, 1'b0);
      send_word(32'h0000_0000, 3'd7, 1'b1);
      // short and empty words inside the message, oversized count mid-message
      send_word(32'hABFF_FFFF, 3'd1, 1'b0);
      send_word($urandom, 3'd0, 1'b0);
      send_word(32'h1234_5600, 3'd3, 1'b0);
      send_word(32'hFFFF_0000, 3'd2, 1'b0);
      send_word(32'hCAFE_F00D, 3'd5, 1'b0);
      send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
      // zero word then a single pad-like byte
      send_word(32'h0000_0000, sm3_pkg::MAX_WORD_BYTES, 1'b0);
      send_word(32'h8000_0000, 3'd1, 1'b1);

      random_phase <= 1'b1;
      stop_at = words_sent + RANDOM_ITEMS;
      while (words_sent < stop_at)
         send_random_message();
      req.valid <= 1'b0;

      do @(posedge clock); while (pending_words != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d messages from %0d words, %0d digest words compared.",
               messages_sent, words_sent, compared_words);
      $display("Receiver stalled on patterns and held off once for %0d cycles.", HOLD_CYCLES);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Digest receiver: its own stall pattern, plus one long hold-off to back the engine up
   initial begin
      int hold_left;
      int mode_left;
      stall_mode_type mode;
      logic [15:0] pattern;
      logic squeezed;
      hold_left = 0;
      mode_left = 0;
      mode      = STALL_NONE;
      pattern   = '1;
      squeezed  = 1'b0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (random_phase && !squeezed) begin
            squeezed  = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 64);
            pattern   = 16'($urandom);
         end
         mode_left--;
         pattern = {pattern[14:0], pattern[15]};
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:    rsp.ready <= 1'b1;
               STALL_PATTERN: rsp.ready <= pattern[0];
               default:       rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d digest words outstanding",
                  idle_cycles, pending_words);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
